[rtl/rls_pkg.sv]
// Shared constants and codes for the reversible LIFO stack.
`timescale 1ns / 1ps

package rls_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;

  // Request codes
  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_PEEK    = 2'd2;
  localparam logic [1:0] REQ_REVERSE = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NEEDLESS = 2'd3;

  // Word returned by a pop or peek on an empty stack
  localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

endpackage

[rtl/rls_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/reversible_lifo_stack.sv]
// Top level of the reversible LIFO stack: request sequencer around one word RAM.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid in_ready in_req_type          | input
//          | in_push_value                          |
//  out     | out_valid out_ready out_result_value   | output
//          | out_status out_fill_level              |
//
// Push, refused push, empty pop/peek and needless reverse are answered from the idle state.
// Pop and peek with data pass through the read state to wait for the registered RAM read.
// Reverse of n entries runs floor(n / 2) swaps: each swap needs two
// reads and two writes through the single RAM read and write ports.
// Reset clears the fill count and the sequencer; the RAM needs no clearing.
// A request is taken when the sequencer is idle and the result register is free.
`timescale 1ns / 1ps

module reversible_lifo_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status,
  output logic [7:0]         out_fill_level
);

  localparam int AW = rls_pkg::ADDR_W;
  localparam int CW = rls_pkg::CNT_W;
  localparam int WW = rls_pkg::WORD_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_READ    = 6'b000010,
    S_RV_RDLO = 6'b000100,
    S_RV_RDHI = 6'b001000,
    S_RV_WRHI = 6'b010000,
    S_RV_WRLO = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   lo_r, lo_nxt;
  logic [AW-1:0]   hi_r, hi_nxt;
  logic [WW-1:0]   swap_r, swap_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [WW-1:0]   out_value_r, out_value_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [CW-1:0]   out_fill_r, out_fill_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [WW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [WW-1:0]   ram_rdata;

  logic            take;
  logic            is_full;
  logic            is_empty;
  logic [AW-1:0]   top_addr;
  logic [AW-1:0]   lo_inc;
  logic [AW-1:0]   hi_dec;

  rls_ram #(
    .WIDTH (WW),
    .DEPTH (rls_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and stack flags
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign take     = in_valid && in_ready;
  assign is_full  = (count_r == CW'(rls_pkg::STACK_DEPTH));
  assign is_empty = (count_r == '0);
  assign top_addr = AW'(count_r - 1'b1);
  assign lo_inc   = lo_r + 1'b1;
  assign hi_dec   = hi_r - 1'b1;

  // Sequence requests and swaps
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    swap_nxt       = swap_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(count_r);
    ram_wdata      = in_push_value;
    ram_raddr      = top_addr;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_req_type)
            rls_pkg::REQ_PUSH: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              if (is_full) begin
                out_status_nxt = rls_pkg::ST_FULL;
                out_fill_nxt   = count_r;
              end else begin
                ram_we         = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_status_nxt = rls_pkg::ST_OK;
                out_fill_nxt   = count_r + 1'b1;
              end
            end
            rls_pkg::REQ_POP: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = rls_pkg::EMPTY_WORD;
                out_status_nxt = rls_pkg::ST_EMPTY;
                out_fill_nxt   = count_r;
              end else begin
                count_nxt = count_r - 1'b1;
                state_nxt = S_READ;
              end
            end
            rls_pkg::REQ_PEEK: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = rls_pkg::EMPTY_WORD;
                out_status_nxt = rls_pkg::ST_EMPTY;
                out_fill_nxt   = count_r;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              // Reverse request
              if (count_r <= CW'(1)) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = rls_pkg::ST_NEEDLESS;
                out_fill_nxt   = count_r;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = top_addr;
                state_nxt = S_RV_RDLO;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // Top word arrives from the RAM
        out_valid_nxt  = 1'b1;
        out_value_nxt  = ram_rdata;
        out_status_nxt = rls_pkg::ST_OK;
        out_fill_nxt   = count_r;
        state_nxt      = S_IDLE;
      end
      S_RV_RDLO: begin
        ram_raddr = lo_r;
        state_nxt = S_RV_RDHI;
      end
      S_RV_RDHI: begin
        ram_raddr = hi_r;
        swap_nxt  = ram_rdata;
        state_nxt = S_RV_WRHI;
      end
      S_RV_WRHI: begin
        // Low word goes up, hold the high word
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = swap_r;
        swap_nxt  = ram_rdata;
        state_nxt = S_RV_WRLO;
      end
      S_RV_WRLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = swap_r;
        lo_nxt    = lo_inc;
        hi_nxt    = hi_dec;
        if (lo_inc < hi_dec) begin
          state_nxt = S_RV_RDLO;
        end else begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = rls_pkg::ST_OK;
          out_fill_nxt   = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    swap_r       <= swap_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_fill_level   = 8'(out_fill_r);

endmodule
